[hw/rtl/ssu_pkg.sv]
// ----------------------------------------------------------------------------
// ssu_pkg
// Shared types, scan mode codes and character constants for the SQL
// statement splitter.
// ----------------------------------------------------------------------------
package ssu_pkg;

  localparam int ModeW  = 4;
  localparam int ByteW  = 8;
  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

  localparam logic [ModeW-1:0] M_IDLE      = 4'd0;
  localparam logic [ModeW-1:0] M_TOP       = 4'd1;
  localparam logic [ModeW-1:0] M_TOP_DOL   = 4'd2;
  localparam logic [ModeW-1:0] M_TOP_DASH  = 4'd3;
  localparam logic [ModeW-1:0] M_TOP_SLASH = 4'd4;
  localparam logic [ModeW-1:0] M_SQ        = 4'd5;
  localparam logic [ModeW-1:0] M_SQ_QUOTE  = 4'd6;
  localparam logic [ModeW-1:0] M_DQ        = 4'd7;
  localparam logic [ModeW-1:0] M_DOL       = 4'd8;
  localparam logic [ModeW-1:0] M_DOL_DOL   = 4'd9;
  localparam logic [ModeW-1:0] M_LINE      = 4'd10;
  localparam logic [ModeW-1:0] M_BLK       = 4'd11;
  localparam logic [ModeW-1:0] M_BLK_STAR  = 4'd12;

  localparam logic [ByteW-1:0] CH_NUL    = 8'h00;
  localparam logic [ByteW-1:0] CH_SEMI   = 8'h3b;
  localparam logic [ByteW-1:0] CH_DOLLAR = 8'h24;
  localparam logic [ByteW-1:0] CH_DASH   = 8'h2d;
  localparam logic [ByteW-1:0] CH_SLASH  = 8'h2f;
  localparam logic [ByteW-1:0] CH_STAR   = 8'h2a;
  localparam logic [ByteW-1:0] CH_SQUOTE = 8'h27;
  localparam logic [ByteW-1:0] CH_DQUOTE = 8'h22;
  localparam logic [ByteW-1:0] CH_LF     = 8'h0a;
  localparam logic [ByteW-1:0] CH_CR     = 8'h0d;
  localparam logic [ByteW-1:0] CH_TAB    = 8'h09;
  localparam logic [ByteW-1:0] CH_SPACE  = 8'h20;

  typedef struct packed {
    logic [ByteW-1:0] out_byte;
    logic             stmt_first;
    logic             stmt_last;
    logic             was_appended;
  } result_t;

  typedef struct packed {
    logic             emit0;
    logic             emit1;
    logic [ModeW-1:0] mode_next;
    result_t          res0;
  } scan_out_t;

  localparam result_t APPENDED_SEMI = '{
    out_byte:     CH_SEMI,
    stmt_first:   1'b0,
    stmt_last:    1'b1,
    was_appended: 1'b1
  };

  function automatic logic [ModeW-1:0] from_top(input logic [ByteW-1:0] c);
    logic [ModeW-1:0] m;
    case (c)
      CH_SQUOTE: m = M_SQ;
      CH_DQUOTE: m = M_DQ;
      CH_DOLLAR: m = M_TOP_DOL;
      CH_DASH:   m = M_TOP_DASH;
      CH_SLASH:  m = M_TOP_SLASH;
      CH_SEMI:   m = M_IDLE;
      default:   m = M_TOP;
    endcase
    return m;
  endfunction

endpackage

[hw/rtl/ssu_in_if.sv]
// ----------------------------------------------------------------------------
// ssu_in_if
// Script byte channel: valid/ready handshake with byte and end-of-script flag.
// ----------------------------------------------------------------------------
interface ssu_in_if import ssu_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] in_byte;
  logic             in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

[hw/rtl/ssu_out_if.sv]
// ----------------------------------------------------------------------------
// ssu_out_if
// Statement byte channel: valid/ready handshake with byte and statement marks.
// ----------------------------------------------------------------------------
interface ssu_out_if import ssu_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] out_byte;
  logic             stmt_first;
  logic             stmt_last;
  logic             was_appended;

  modport source (output valid, output out_byte, output stmt_first,
                  output stmt_last, output was_appended, input ready);
  modport sink   (input valid, input out_byte, input stmt_first,
                  input stmt_last, input was_appended, output ready);
endinterface

[hw/rtl/ssu_scan.sv]
// ----------------------------------------------------------------------------
// ssu_scan
// Per-byte lexer step: next scan mode and the results one byte produces.
// ----------------------------------------------------------------------------
module ssu_scan import ssu_pkg::*; (
  input  logic [ModeW-1:0] mode,
  input  logic [ByteW-1:0] in_byte,
  input  logic             in_last,
  output scan_out_t        scan
);

  logic [ModeW-1:0] eff;
  logic [ModeW-1:0] next;
  logic             skip;
  logic             first;
  logic             top_path;
  logic             ends;
  logic             is_space;

  assign is_space = (in_byte == CH_SPACE) || (in_byte == CH_TAB) ||
                    (in_byte == CH_LF) || (in_byte == CH_CR);

  always_comb begin
    eff      = mode;
    skip     = 1'b0;
    first    = 1'b0;
    next     = mode;
    top_path = 1'b0;

    if (in_byte == CH_NUL) begin
      skip = 1'b1;
    end else if (mode == M_IDLE) begin
      if (is_space || in_byte == CH_SEMI) begin
        skip = 1'b1;
      end else begin
        first = 1'b1;
        eff   = M_TOP;
      end
    end

    unique case (eff)
      M_TOP_DOL: begin
        if (in_byte == CH_DOLLAR) next = M_DOL;
        else top_path = 1'b1;
      end
      M_TOP_DASH: begin
        if (in_byte == CH_DASH) next = M_LINE;
        else top_path = 1'b1;
      end
      M_TOP_SLASH: begin
        if (in_byte == CH_STAR) next = M_BLK;
        else top_path = 1'b1;
      end
      M_SQ_QUOTE: begin
        if (in_byte == CH_SQUOTE) next = M_SQ;
        else top_path = 1'b1;
      end
      M_SQ:       next = (in_byte == CH_SQUOTE) ? M_SQ_QUOTE : M_SQ;
      M_DQ:       next = (in_byte == CH_DQUOTE) ? M_TOP : M_DQ;
      M_DOL:      next = (in_byte == CH_DOLLAR) ? M_DOL_DOL : M_DOL;
      M_DOL_DOL:  next = (in_byte == CH_DOLLAR) ? M_TOP : M_DOL;
      M_LINE:     next = (in_byte == CH_LF) ? M_TOP : M_LINE;
      M_BLK:      next = (in_byte == CH_STAR) ? M_BLK_STAR : M_BLK;
      M_BLK_STAR: begin
        if (in_byte == CH_SLASH) next = M_TOP;
        else if (in_byte == CH_STAR) next = M_BLK_STAR;
        else next = M_BLK;
      end
      default:    top_path = 1'b1;
    endcase

    if (top_path) next = from_top(in_byte);

    ends = (top_path && in_byte == CH_SEMI) || (in_last && in_byte == CH_SEMI);

    scan.emit0               = !skip;
    scan.emit1               = !skip && in_last && !ends;
    scan.mode_next           = skip ? mode : (in_last ? M_IDLE : next);
    scan.res0.out_byte       = in_byte;
    scan.res0.stmt_first     = first;
    scan.res0.stmt_last      = ends;
    scan.res0.was_appended   = 1'b0;
  end

endmodule

[hw/rtl/ssu_fifo.sv]
// ----------------------------------------------------------------------------
// ssu_fifo
// Small result queue: takes up to two results per cycle, hands out one when the reader is ready.
// ----------------------------------------------------------------------------
module ssu_fifo import ssu_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push0,
  input  logic    push1,
  input  result_t d0,
  input  result_t d1,
  output logic    space2,
  output logic    pop_valid,
  input  logic    pop_ready,
  output result_t pop_data
);

  result_t             mem [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr;
  logic [FifoPtrW-1:0] rd_ptr;
  logic [FifoCntW-1:0] count;
  logic [FifoPtrW-1:0] wr_ptr1;
  logic [FifoCntW-1:0] npush;
  logic                pop;

  assign wr_ptr1   = wr_ptr + FifoPtrW'(1);
  assign npush     = FifoCntW'(push0) + FifoCntW'(push1);
  assign pop_valid = (count != '0);
  assign pop       = pop_valid && pop_ready;
  assign pop_data  = mem[rd_ptr];
  assign space2    = (count <= FifoCntW'(FifoDepth - 2));

  always_ff @(posedge clk) begin
    if (push0) mem[wr_ptr] <= d0;
    if (push1) mem[wr_ptr1] <= d1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + FifoPtrW'(npush);
      if (pop) rd_ptr <= rd_ptr + FifoPtrW'(1);
      count  <= count + npush - FifoCntW'(pop);
    end
  end

endmodule

[hw/rtl/sql_statement_splitter_unit.sv]
// ----------------------------------------------------------------------------
// sql_statement_splitter_unit
// Splits SQL script bytes into statements, one byte per cycle unless stalled.
// ----------------------------------------------------------------------------
//  port  | dir  | item
//  ------+------+----------------------------------------------------------
//  in    | sink | in_byte, in_last: one script byte
//  out   | src  | out_byte, stmt_first, stmt_last, was_appended
//
//  one byte per cycle if queue has room; registered in input stage, then queue
//  the 4-bit scan mode register is updated once per byte in the scan stage
//  a byte that ends the script may emit a second item (appended semicolon)
//  a four-entry result queue decouples output stalls from input by a few items
//  synchronous reset returns the scan mode to between-statements, queue empty
// ----------------------------------------------------------------------------
module sql_statement_splitter_unit import ssu_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  ssu_in_if.sink    in,
  ssu_out_if.source out
);

  logic             s1_valid;
  logic [ByteW-1:0] s1_byte;
  logic             s1_last;
  logic [ModeW-1:0] mode;
  logic             s1_take;
  logic             space2;
  logic             accept;
  scan_out_t        scan;
  result_t          head;

  assign s1_take  = s1_valid && space2;
  assign in.ready = !s1_valid || space2;
  assign accept   = in.valid && in.ready;

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte <= in.in_byte;
      s1_last <= in.in_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      mode     <= M_IDLE;
    end else begin
      if (accept) s1_valid <= 1'b1;
      else if (s1_take) s1_valid <= 1'b0;
      if (s1_take) mode <= scan.mode_next;
    end
  end

  ssu_scan u_scan (
    .mode    (mode),
    .in_byte (s1_byte),
    .in_last (s1_last),
    .scan    (scan)
  );

  ssu_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push0     (s1_take && scan.emit0),
    .push1     (s1_take && scan.emit1),
    .d0        (scan.res0),
    .d1        (APPENDED_SEMI),
    .space2    (space2),
    .pop_valid (out.valid),
    .pop_ready (out.ready),
    .pop_data  (head)
  );

  assign out.out_byte     = head.out_byte;
  assign out.stmt_first   = head.stmt_first;
  assign out.stmt_last    = head.stmt_last;
  assign out.was_appended = head.was_appended;

  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (s1_take && s1_last && s1_byte != CH_NUL) |=> (mode == M_IDLE))
    else $error("scan mode not idle after script end");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_take) |=> (s1_valid && $stable(s1_byte) && $stable(s1_last)))
    else $error("input stage lost a waiting byte");

  a_append_only_at_end: assert property (@(posedge clk) disable iff (rst)
    (s1_take && scan.emit1) |-> (scan.emit0 && s1_last))
    else $error("appended semicolon outside script end");

  a_nul_keeps_mode: assert property (@(posedge clk) disable iff (rst)
    (s1_take && s1_byte == CH_NUL) |=> $stable(mode))
    else $error("nul byte changed scan mode");

endmodule

[sim/ssu_stmt_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ssu_stmt_checker
// Watches the script byte and statement byte channels of the splitter, keeps
// its own scan mode, works out the statement bytes due for every accepted
// script byte and compares each delivered item with the oldest one due.
// ----------------------------------------------------------------------------
module ssu_stmt_checker import ssu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  ssu_in_if           in_ch,
  ssu_out_if          out_ch,
  output int unsigned fail_count,
  output int unsigned pending
);

  localparam int unsigned MaxShown = 40;

  logic [ModeW-1:0] cur_mode;
  logic [ModeW-1:0] nxt_mode;
  int               n_res;
  result_t          res_a;
  result_t          res_b;
  result_t          want;
  result_t          stmt_bytes_due[$];

  initial begin
    fail_count = 0;
    pending    = 0;
    cur_mode   = M_IDLE;
  end

  task automatic note_error(input string msg);
    if (fail_count < MaxShown) begin
      $display("%0t ns: mismatch: %s", $time, msg);
    end
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [ByteW-1:0] got,
                             input logic [ByteW-1:0] exp_val);
    if (got !== exp_val) begin
      note_error($sformatf("%s got %0h want %0h", name, got, exp_val));
    end
  endtask

  function automatic bit is_blank(input logic [ByteW-1:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
  endfunction

  // mode reached from top level on byte c
  function automatic logic [ModeW-1:0] top_next(input logic [ByteW-1:0] c);
    case (c)
      CH_SQUOTE: return M_SQ;
      CH_DQUOTE: return M_DQ;
      CH_DOLLAR: return M_TOP_DOL;
      CH_DASH:   return M_TOP_DASH;
      CH_SLASH:  return M_TOP_SLASH;
      CH_SEMI:   return M_IDLE;
      default:   return M_TOP;
    endcase
  endfunction

  function automatic void scan_byte(input logic [ModeW-1:0] mode_in,
                                    input logic [ByteW-1:0] c, input logic l,
                                    output logic [ModeW-1:0] mode_out,
                                    output int n, output result_t r0,
                                    output result_t r1);
    logic [ModeW-1:0] m;
    logic [ModeW-1:0] nxt;
    bit               first;
    bit               ends;
    bit               at_top;
    n        = 0;
    r0       = '0;
    r1       = '0;
    mode_out = mode_in;
    first    = 1'b0;
    ends     = 1'b0;
    at_top   = 1'b0;
    nxt      = M_TOP;
    m        = mode_in;
    if (c == CH_NUL) begin
      return;
    end
    if (m == M_IDLE) begin
      if (is_blank(c) || c == CH_SEMI) begin
        return;
      end
      first = 1'b1;
      m     = M_TOP;
    end
    case (m)
      M_TOP_DOL: begin
        if (c == CH_DOLLAR) nxt = M_DOL;
        else at_top = 1'b1;
      end
      M_TOP_DASH: begin
        if (c == CH_DASH) nxt = M_LINE;
        else at_top = 1'b1;
      end
      M_TOP_SLASH: begin
        if (c == CH_STAR) nxt = M_BLK;
        else at_top = 1'b1;
      end
      M_SQ_QUOTE: begin
        if (c == CH_SQUOTE) nxt = M_SQ;
        else at_top = 1'b1;
      end
      M_SQ:       nxt = (c == CH_SQUOTE) ? M_SQ_QUOTE : M_SQ;
      M_DQ:       nxt = (c == CH_DQUOTE) ? M_TOP : M_DQ;
      M_DOL:      nxt = (c == CH_DOLLAR) ? M_DOL_DOL : M_DOL;
      M_DOL_DOL:  nxt = (c == CH_DOLLAR) ? M_TOP : M_DOL;
      M_LINE:     nxt = (c == CH_LF) ? M_TOP : M_LINE;
      M_BLK:      nxt = (c == CH_STAR) ? M_BLK_STAR : M_BLK;
      M_BLK_STAR: nxt = (c == CH_SLASH) ? M_TOP : ((c == CH_STAR) ? M_BLK_STAR : M_BLK);
      default:    at_top = 1'b1;
    endcase
    if (at_top) begin
      nxt  = top_next(c);
      ends = (c == CH_SEMI);
    end
    if (l && c == CH_SEMI) begin
      ends = 1'b1;
    end
    r0 = '{out_byte: c, stmt_first: first, stmt_last: ends, was_appended: 1'b0};
    n  = 1;
    if (l && !ends) begin
      r1 = '{out_byte: CH_SEMI, stmt_first: 1'b0, stmt_last: 1'b1, was_appended: 1'b1};
      n  = 2;
    end
    mode_out = l ? M_IDLE : nxt;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      cur_mode = M_IDLE;
      stmt_bytes_due.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        scan_byte(cur_mode, in_ch.in_byte, in_ch.in_last, nxt_mode, n_res, res_a, res_b);
        cur_mode = nxt_mode;
        if (n_res > 0) stmt_bytes_due.push_back(res_a);
        if (n_res > 1) stmt_bytes_due.push_back(res_b);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (stmt_bytes_due.size() == 0) begin
          note_error($sformatf("item %0h with nothing due", out_ch.out_byte));
        end else begin
          want = stmt_bytes_due.pop_front();
          check_field("out_byte", out_ch.out_byte, want.out_byte);
          check_field("stmt_first", ByteW'(out_ch.stmt_first), ByteW'(want.stmt_first));
          check_field("stmt_last", ByteW'(out_ch.stmt_last), ByteW'(want.stmt_last));
          check_field("was_appended", ByteW'(out_ch.was_appended),
                      ByteW'(want.was_appended));
        end
      end
    end
    pending = stmt_bytes_due.size();
  end

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Feeds the statement splitter with short directed scripts and then random
// scripts built from words, quoted text, dollar blocks, comments and noise,
// under changing input gaps and output stalls; the checker gives the verdict.
// ----------------------------------------------------------------------------
module testbench import ssu_pkg::*; ();

  localparam int unsigned PhaseItems = 250;
  localparam int unsigned HoldCycles = 48;

  logic clk;
  logic rst;

  ssu_in_if  in_ch ();
  ssu_out_if out_ch ();

  int unsigned fail_count;
  int unsigned pending;

  int unsigned send_idle;
  int unsigned recv_idle;
  int unsigned holds_asked;
  int unsigned holds_done;
  int unsigned hold_left;
  int unsigned sent_items;
  logic [ByteW-1:0] script_q[$];

  sql_statement_splitter_unit i_dut (
    .clk (clk),
    .rst (rst),
    .in  (in_ch),
    .out (out_ch)
  );

  ssu_stmt_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAIL sql_statement_splitter_unit");
    $finish;
  end

  // output side: random stalls plus long hold-offs on request
  initial begin
    out_ch.ready = 1'b0;
    holds_done   = 0;
    hold_left    = 0;
    @(negedge clk);
    forever begin
      if (holds_done != holds_asked) begin
        holds_done = holds_asked;
        hold_left  = HoldCycles;
      end
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle);
      end
      @(negedge clk);
    end
  end

  // entered and left at a falling edge
  task automatic send_byte(input logic [ByteW-1:0] b, input logic l);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.in_last <= l;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (b != CH_NUL) sent_items++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s, input bit last_at_end);
    for (int i = 0; i < s.len(); i++) begin
      send_byte(s[i], last_at_end && (i == s.len() - 1));
    end
  endtask

  task automatic drain;
    in_ch.valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);
  endtask

  function automatic logic [ByteW-1:0] any_byte();
    return ByteW'($urandom_range(255, 1));
  endfunction

  function automatic logic [ByteW-1:0] body_byte();
    return ($urandom_range(3) == 0) ? CH_SEMI : any_byte();
  endfunction

  function automatic logic [ByteW-1:0] blank_byte();
    case ($urandom_range(3))
      0:       return CH_SPACE;
      1:       return CH_TAB;
      2:       return CH_LF;
      default: return CH_CR;
    endcase
  endfunction

  task automatic add_token;
    logic [ByteW-1:0] b;
    int               len;
    len = $urandom_range(4);
    case ($urandom_range(9))
      0: begin
        repeat (len + 1) script_q.push_back(ByteW'($urandom_range(8'h7a, 8'h61)));
      end
      1: begin
        script_q.push_back(CH_SQUOTE);
        repeat (len) begin
          b = body_byte();
          script_q.push_back(b);
          if (b == CH_SQUOTE) script_q.push_back(CH_SQUOTE);
        end
        script_q.push_back(CH_SQUOTE);
      end
      2: begin
        script_q.push_back(CH_DQUOTE);
        repeat (len) begin
          b = body_byte();
          script_q.push_back((b == CH_DQUOTE) ? CH_SEMI : b);
        end
        script_q.push_back(CH_DQUOTE);
      end
      3: begin
        script_q.push_back(CH_DOLLAR);
        script_q.push_back(CH_DOLLAR);
        repeat (len) begin
          b = body_byte();
          script_q.push_back(b);
          if (b == CH_DOLLAR) script_q.push_back(CH_SEMI);
        end
        script_q.push_back(CH_DOLLAR);
        script_q.push_back(CH_DOLLAR);
      end
      4: begin
        script_q.push_back(CH_DASH);
        script_q.push_back(CH_DASH);
        repeat (len) begin
          b = body_byte();
          script_q.push_back((b == CH_LF) ? CH_SEMI : b);
        end
        script_q.push_back(CH_LF);
      end
      5: begin
        script_q.push_back(CH_SLASH);
        script_q.push_back(CH_STAR);
        repeat (len) begin
          b = body_byte();
          script_q.push_back((b == CH_STAR) ? CH_SEMI : b);
          if ($urandom_range(3) == 0) script_q.push_back(CH_STAR);
        end
        if ($urandom_range(1) == 0) script_q.push_back(CH_STAR);
        script_q.push_back(CH_STAR);
        script_q.push_back(CH_SLASH);
      end
      6: begin
        case ($urandom_range(2))
          0:       script_q.push_back(CH_DOLLAR);
          1:       script_q.push_back(CH_DASH);
          default: script_q.push_back(CH_SLASH);
        endcase
        script_q.push_back(any_byte());
      end
      7: begin
        repeat (len + 1) begin
          script_q.push_back(($urandom_range(19) == 0) ? CH_NUL : any_byte());
        end
      end
      8: begin
        repeat (len + 1) script_q.push_back(blank_byte());
      end
      default: begin
        repeat (len + 1) script_q.push_back(ByteW'($urandom_range(8'hff, 8'h80)));
      end
    endcase
  endtask

  task automatic send_script;
    int cut;
    script_q.delete();
    if ($urandom_range(3) == 0) begin
      repeat ($urandom_range(3, 1)) begin
        script_q.push_back(($urandom_range(1) == 0) ? CH_SEMI : blank_byte());
      end
    end
    repeat ($urandom_range(3, 1)) begin
      repeat ($urandom_range(5, 1)) add_token();
      if ($urandom_range(9) != 0) script_q.push_back(CH_SEMI);
      if ($urandom_range(2) == 0) script_q.push_back(blank_byte());
    end
    // broken script: ends in the middle of something
    if ($urandom_range(5) == 0) begin
      cut = $urandom_range(script_q.size(), 1);
      while (script_q.size() > cut) void'(script_q.pop_back());
    end
    foreach (script_q[i]) begin
      send_byte(script_q[i], i == script_q.size() - 1);
    end
  endtask

  initial begin
    rst           = 1'b1;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = CH_NUL;
    in_ch.in_last = 1'b0;
    send_idle     = 0;
    recv_idle     = 0;
    holds_asked   = 0;
    sent_items    = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_text(" ;", 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(CH_NUL, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(CH_SEMI, 1'b0);
    send_text("$$;$$;", 1'b1);
    send_text("'x;", 1'b1);
    send_text("-/", 1'b1);
    send_text("\t\n\r", 1'b1);
    drain();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle = 26;
          recv_idle = 75;
        end
        1: begin
          send_idle = 75;
          recv_idle = 26;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      if (phase != 1) holds_asked++;
      sent_items = 0;
      while (sent_items < PhaseItems) send_script();
      drain();
    end

    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS sql_statement_splitter_unit");
    end else begin
      $display("FAIL sql_statement_splitter_unit");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/ssu_pkg.sv
hw/rtl/ssu_in_if.sv
hw/rtl/ssu_out_if.sv
hw/rtl/ssu_scan.sv
hw/rtl/ssu_fifo.sv
hw/rtl/sql_statement_splitter_unit.sv
sim/ssu_stmt_checker.sv
sim/testbench.sv
